@@ sv/gww_pkg.sv @@
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types and constants of the greedy word-wrap stream core: command
// codes between front and back, result layout, character codes and the
// register map.
// ----------------------------------------------------------------------------
package gww_pkg;

	// command classes produced by the front part
	typedef enum logic [1:0] {
		CMD_CHAR = 2'd0,
		CMD_SEP  = 2'd1,
		CMD_LF   = 2'd2,
		CMD_END  = 2'd3
	} cmd_kind_t;

	// one classified input request
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  text;
	} cmd_t;

	// result kinds
	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_EOL     = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// one result request without its last marker
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] lines;
		logic       trunc;
	} result_t;

	// configuration handed to the back part
	typedef struct packed {
		logic [5:0] wrap_width;
		logic [7:0] line_limit;
	} cfg_t;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// register map, index taken from paddr[2]
	localparam logic REG_WRAP_WIDTH = 1'b0;
	localparam logic REG_LINE_LIMIT = 1'b1;
	localparam int   APB_ADDR_W     = 3;

	localparam logic [5:0] WRAP_WIDTH_RESET = 6'd32;
	localparam logic [7:0] LINE_LIMIT_RESET = 8'd255;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

endpackage

@@ sv/gww_front.sv @@
// ----------------------------------------------------------------------------
// gww_front
// Accepts input requests, sorts each into character, separator, line feed or
// end of text, and queues it for the back part.
// ----------------------------------------------------------------------------
module gww_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] text_byte
	input  logic                s_tlast,   // end_of_text
	output logic                head_valid,
	output gww_pkg::cmd_t       head,
	input  logic                pop
);

	gww_pkg::cmd_t                    q_mem_q [gww_pkg::QUEUE_DEPTH];
	logic [gww_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [gww_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [gww_pkg::QUEUE_AW:0]       count_q;
	logic                             push;
	logic                             do_pop;
	gww_pkg::cmd_t                    cmd_in;

	// sort a byte into its command class
	function automatic gww_pkg::cmd_t classify(input logic [7:0] b, input logic eot);
		gww_pkg::cmd_t c;
		c.text = b;
		if (eot) begin
			c.kind = gww_pkg::CMD_END;
		end else if (b == gww_pkg::CH_SPACE || b == gww_pkg::CH_TAB ||
				b == gww_pkg::CH_CR) begin
			c.kind = gww_pkg::CMD_SEP;
		end else if (b == gww_pkg::CH_LF) begin
			c.kind = gww_pkg::CMD_LF;
		end else begin
			c.kind = gww_pkg::CMD_CHAR;
		end
		return c;
	endfunction

	assign cmd_in     = classify(s_tdata, s_tlast);
	assign s_tready   = count_q != (gww_pkg::QUEUE_AW + 1)'(gww_pkg::QUEUE_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign head_valid = count_q != '0;
	assign head       = q_mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (!push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// queue entries
	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

@@ sv/gww_back.sv @@
// ----------------------------------------------------------------------------
// gww_back
// Sequencer that carries out queued commands: buffers the current word, places
// words on the line, splits long words, counts lines and, unless the output
// stalls, emits one result per cycle through a hold stage and output register.
// ----------------------------------------------------------------------------
module gww_back #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gww_pkg::cfg_t       cfg,
	input  logic                head_valid,
	input  gww_pkg::cmd_t       head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output gww_pkg::result_t    out_res,
	output logic                out_last
);

	localparam int LW = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(MAX_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_PLACE,
		ST_WORD,
		ST_CHUNK_EOL,
		ST_POST,
		ST_SUMMARY,
		ST_FINISH
	} state_t;

	state_t              state_q, state_d;
	gww_pkg::cmd_t       cmd_q, cmd_d;
	logic [LW-1:0]       wlen_q, wlen_d;
	logic [LW-1:0]       llen_q, llen_d;
	logic [7:0]          lines_q, lines_d;
	logic                trunc_q, trunc_d;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic [LW-1:0]       cnt_q, cnt_d;
	logic                chunk_q, chunk_d;
	gww_pkg::result_t    hold_q, hold_d;
	logic                hold_v_q, hold_v_d;
	gww_pkg::result_t    out_q, out_d;
	logic                out_last_q, out_last_d;
	logic                out_v_q, out_v_d;

	logic [7:0]          mem [MAX_WIDTH];
	logic [7:0]          rdata_q;
	logic [AW-1:0]       raddr;
	logic                mem_we;

	logic [LW-1:0]       width_eff;
	logic [LW-1:0]       wl;
	logic [LW:0]         fit_sum;
	logic                sup;
	logic [7:0]          lines_inc;
	logic                close_drop;
	logic                slot_free;
	logic                can_emit;
	logic                last_char;
	logic                emit;
	logic                push_last;
	gww_pkg::result_t    emit_res;
	gww_pkg::result_t    close_res;

	// effective width: zero reads as one, clamped to the store depth
	always_comb begin
		if (cfg.wrap_width == '0) begin
			width_eff = LW'(1);
		end else if (cfg.wrap_width > 6'(MAX_WIDTH)) begin
			width_eff = LW'(MAX_WIDTH);
		end else begin
			width_eff = LW'(cfg.wrap_width);
		end
	end

	assign sup        = lines_q >= cfg.line_limit;
	assign wl         = (wlen_q < width_eff) ? wlen_q : width_eff;
	assign fit_sum    = {1'b0, llen_q} + {1'b0, wl} + (LW + 1)'(1);
	assign lines_inc  = lines_q + 8'd1;
	assign close_drop = (lines_inc >= cfg.line_limit) && (wlen_q != '0);
	assign slot_free  = !out_v_q || out_ready;
	assign can_emit   = !hold_v_q || slot_free;
	assign last_char  = (LW'(ptr_q) + LW'(1)) == cnt_q;

	always_comb begin
		close_res.kind  = gww_pkg::KIND_EOL;
		close_res.data  = 8'h00;
		close_res.lines = lines_inc;
		close_res.trunc = trunc_q | close_drop;
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		wlen_d   = wlen_q;
		llen_d   = llen_q;
		lines_d  = lines_q;
		trunc_d  = trunc_q;
		ptr_d    = ptr_q;
		cnt_d    = cnt_q;
		chunk_d  = chunk_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		emit     = 1'b0;
		push_last = 1'b0;
		emit_res = close_res;
		raddr    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop   = 1'b1;
					cmd_d = head;
					if (head.kind == gww_pkg::CMD_END) begin
						if (sup) begin
							if (wlen_q != '0 || llen_q != '0) trunc_d = 1'b1;
							wlen_d  = '0;
							llen_d  = '0;
							state_d = ST_SUMMARY;
						end else begin
							state_d = ST_PLACE;
						end
					end else if (sup) begin
						// suppressed text is dropped, non-blank marks truncation
						if (wlen_q != '0 || llen_q != '0) trunc_d = 1'b1;
						if (head.kind == gww_pkg::CMD_CHAR) trunc_d = 1'b1;
						wlen_d = '0;
						llen_d = '0;
					end else begin
						unique case (head.kind)
							gww_pkg::CMD_SEP: begin
								if (wlen_q != '0) state_d = ST_PLACE;
							end
							gww_pkg::CMD_LF: begin
								if (wlen_q != '0 || llen_q != '0) state_d = ST_PLACE;
							end
							gww_pkg::CMD_CHAR: begin
								if (wlen_q < width_eff) begin
									mem_we = 1'b1;
									wlen_d = wlen_q + LW'(1);
								end else begin
									state_d = ST_CHAR;
								end
							end
							gww_pkg::CMD_END: begin
								state_d = ST_PLACE;
							end
						endcase
					end
				end
			end

			// full word buffer: close open line, emit a chunk, then store
			ST_CHAR: begin
				if (wlen_q >= width_eff && llen_q != '0 && !sup) begin
					if (can_emit) begin
						emit    = 1'b1;
						lines_d = lines_inc;
						llen_d  = '0;
						if (close_drop) begin
							trunc_d = 1'b1;
							wlen_d  = '0;
						end
					end
				end else if (wlen_q >= width_eff && !sup) begin
					cnt_d   = width_eff;
					ptr_d   = '0;
					chunk_d = 1'b1;
					state_d = ST_WORD;
				end else begin
					if (sup) begin
						trunc_d = 1'b1;
						wlen_d  = '0;
						llen_d  = '0;
					end else begin
						mem_we = 1'b1;
						wlen_d = wlen_q + LW'(1);
					end
					state_d = ST_FINISH;
				end
			end

			// place the pending word on the open line or a new one
			ST_PLACE: begin
				if (wl == '0) begin
					state_d = ST_POST;
				end else if (sup) begin
					if (wlen_q != '0 || llen_q != '0) trunc_d = 1'b1;
					wlen_d  = '0;
					llen_d  = '0;
					state_d = ST_POST;
				end else if (llen_q != '0 && fit_sum > {1'b0, width_eff}) begin
					if (can_emit) begin
						emit    = 1'b1;
						lines_d = lines_inc;
						llen_d  = '0;
						if (close_drop) begin
							trunc_d = 1'b1;
							wlen_d  = '0;
						end
					end
				end else if (llen_q != '0) begin
					if (can_emit) begin
						emit           = 1'b1;
						emit_res.kind  = gww_pkg::KIND_CHAR;
						emit_res.data  = gww_pkg::CH_SPACE;
						emit_res.lines = lines_q;
						emit_res.trunc = trunc_q;
						llen_d  = llen_q + LW'(1);
						cnt_d   = wl;
						ptr_d   = '0;
						chunk_d = 1'b0;
						state_d = ST_WORD;
					end
				end else begin
					cnt_d   = wl;
					ptr_d   = '0;
					chunk_d = 1'b0;
					state_d = ST_WORD;
				end
			end

			// stream word characters from the store
			ST_WORD: begin
				raddr = ptr_q;
				if (can_emit) begin
					emit           = 1'b1;
					emit_res.kind  = gww_pkg::KIND_CHAR;
					emit_res.data  = rdata_q;
					emit_res.lines = lines_q;
					emit_res.trunc = trunc_q;
					if (last_char) begin
						llen_d  = llen_q + cnt_q;
						wlen_d  = '0;
						state_d = chunk_q ? ST_CHUNK_EOL : ST_POST;
					end else begin
						ptr_d = ptr_q + AW'(1);
						raddr = ptr_q + AW'(1);
					end
				end
			end

			// a chunk of a long word is a line of its own
			ST_CHUNK_EOL: begin
				if (sup) begin
					state_d = ST_CHAR;
				end else if (can_emit) begin
					emit    = 1'b1;
					lines_d = lines_inc;
					llen_d  = '0;
					if (close_drop) begin
						trunc_d = 1'b1;
						wlen_d  = '0;
					end
					state_d = ST_CHAR;
				end
			end

			// line feed and end of text close the open line
			ST_POST: begin
				if (cmd_q.kind != gww_pkg::CMD_SEP && llen_q != '0 && !sup) begin
					if (can_emit) begin
						emit    = 1'b1;
						lines_d = lines_inc;
						llen_d  = '0;
						if (close_drop) begin
							trunc_d = 1'b1;
							wlen_d  = '0;
						end
						state_d = (cmd_q.kind == gww_pkg::CMD_END) ? ST_SUMMARY : ST_FINISH;
					end
				end else begin
					state_d = (cmd_q.kind == gww_pkg::CMD_END) ? ST_SUMMARY : ST_FINISH;
				end
			end

			// totals, then start a fresh text
			ST_SUMMARY: begin
				if (can_emit) begin
					emit           = 1'b1;
					emit_res.kind  = gww_pkg::KIND_SUMMARY;
					emit_res.data  = 8'h00;
					emit_res.lines = lines_q;
					emit_res.trunc = trunc_q;
					wlen_d  = '0;
					llen_d  = '0;
					lines_d = '0;
					trunc_d = 1'b0;
					state_d = ST_FINISH;
				end
			end

			// release the held result as the final one of the request
			ST_FINISH: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (slot_free) begin
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold stage and output register
	always_comb begin
		hold_d     = hold_q;
		hold_v_d   = hold_v_q;
		out_d      = out_q;
		out_last_d = out_last_q;
		out_v_d    = out_v_q;
		if (out_ready) out_v_d = 1'b0;
		if (emit) begin
			hold_d   = emit_res;
			hold_v_d = 1'b1;
			if (hold_v_q) begin
				out_d      = hold_q;
				out_last_d = 1'b0;
				out_v_d    = 1'b1;
			end
		end else if (push_last) begin
			hold_v_d   = 1'b0;
			out_d      = hold_q;
			out_last_d = 1'b1;
			out_v_d    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= '0;
			wlen_q     <= '0;
			llen_q     <= '0;
			lines_q    <= '0;
			trunc_q    <= 1'b0;
			ptr_q      <= '0;
			cnt_q      <= '0;
			chunk_q    <= 1'b0;
			hold_q     <= '0;
			hold_v_q   <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmd_q      <= cmd_d;
			wlen_q     <= wlen_d;
			llen_q     <= llen_d;
			lines_q    <= lines_d;
			trunc_q    <= trunc_d;
			ptr_q      <= ptr_d;
			cnt_q      <= cnt_d;
			chunk_q    <= chunk_d;
			hold_q     <= hold_d;
			hold_v_q   <= hold_v_d;
			out_q      <= out_d;
			out_last_q <= out_last_d;
			out_v_q    <= out_v_d;
		end
	end

	// word store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wlen_q[AW-1:0]] <= (state_q == ST_IDLE) ? head.text : cmd_q.text;
		end
		rdata_q <= mem[raddr];
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

@@ sv/greedy_word_wrap_stream_core.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream_core
// Greedy word wrapper for a byte stream. One text byte per input request
// (s_tlast marks end of text); results are characters, line ends and a final
// summary with the line count and the truncated flag, the last result of each
// request carrying m_tlast. A character that extends the current word, and a
// blank that has nothing to flush, is taken straight in the idle state. A
// separator, line feed, end of text or a character that cuts a full word
// goes through further steps: popping the request, deciding where the
// word goes, closing or skipping the line end, and releasing the final result.
// A single sequencer emits all results one per cycle, and each result waits
// in a hold stage until the next one is known so that the last can be marked.
// A two-entry command queue sits between the input classifier and the
// sequencer, and results leave through an output register, so either side
// may stall independently; a stalled result side holds the sequencer.
// ----------------------------------------------------------------------------
module greedy_word_wrap_stream_core #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [7:0] text_byte
	input  logic                              s_tlast,  // end_of_text
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,  // [7:0] out_byte, [15:8] line_count,
	                                                    // [16] truncated, [23:17] zero
	output logic [1:0]                        m_tuser,  // kind
	output logic                              m_tlast,  // last
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gww_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [5:0]          wrap_width_q;
	logic [7:0]          line_limit_q;
	logic                cfg_we;
	gww_pkg::cfg_t       cfg;
	logic                head_valid;
	gww_pkg::cmd_t       head;
	logic                pop;
	gww_pkg::result_t    res;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= gww_pkg::WRAP_WIDTH_RESET;
			line_limit_q <= gww_pkg::LINE_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (paddr[2])
				gww_pkg::REG_WRAP_WIDTH: wrap_width_q <= pwdata[5:0];
				gww_pkg::REG_LINE_LIMIT: line_limit_q <= pwdata[7:0];
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[2])
			gww_pkg::REG_WRAP_WIDTH: prdata = {26'd0, wrap_width_q};
			gww_pkg::REG_LINE_LIMIT: prdata = {24'd0, line_limit_q};
		endcase
	end

	assign cfg.wrap_width = wrap_width_q;
	assign cfg.line_limit = line_limit_q;

	gww_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	gww_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res),
		.out_last   (m_tlast)
	);

	// result packing
	assign m_tdata = {7'd0, res.trunc, res.lines, res.data};
	assign m_tuser = res.kind;

endmodule
